### sv/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TSN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsn assertion failed");

// next-cycle implication, disabled during reset
`define TSN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsn assertion failed");

`endif

### sv/tsn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsn_pkg;

    localparam int POS_W      = 17;
    localparam int SCALE_W    = 11;
    localparam int SCALE_FRAC = 8;
    localparam int SCALED_W   = POS_W + SCALE_W - SCALE_FRAC;
    localparam int GSIZE_W    = 6;
    localparam int WEIGHT_W   = 24;
    localparam int IDX_W      = 5;
    localparam int VALUE_W    = 48;
    localparam int WSUM_W     = 32;
    localparam int STORE_W    = VALUE_W + WSUM_W;
    localparam int COEF_W     = 17;
    localparam int PROD_W     = WEIGHT_W + COEF_W + 1;
    localparam int NUM_W      = 64;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_X = 2'd0,
        CFG_GRID_Y = 2'd1,
        CFG_GRID_Z = 2'd2,
        CFG_SCALE  = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        KIND_SPLAT = 1'b0,
        KIND_READ  = 1'b1
    } item_kind_t;

endpackage

`default_nettype wire

### sv/tsn_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsn_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic signed [23:0] atom_weight;
    logic [4:0]  read_x;
    logic [4:0]  read_y;
    logic [4:0]  read_z;

    modport source (output valid, kind, pos_x, pos_y, pos_z, atom_weight,
                    read_x, read_y, read_z, input ready);
    modport sink (input valid, kind, pos_x, pos_y, pos_z, atom_weight,
                  read_x, read_y, read_z, output ready);
endinterface

interface tsn_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] voxel_value;
    logic               saturated;

    modport source (output valid, voxel_value, saturated, input ready);
    modport sink (input valid, voxel_value, saturated, output ready);
endinterface

`default_nettype wire

### sv/tsn_store.sv
`timescale 1ns / 1ps
`default_nettype none

module tsn_store #(
    parameter int AW    = 15,
    parameter int DW    = 80,
    parameter int DEPTH = 32768
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/tsn_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module tsn_div #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quot
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW:0]      rem_reg, rem_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW:0]      rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg[DW-1:0], quo_reg[NW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NW);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

### sv/trilinear_splat_normalize_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// trilinear splat and normalized read-out over a cubic voxel grid
// items: valid/ready input channel; kind selects splat (no result) or read
//   (one result on the results channel); transfer when valid and ready are high
// results: valid/ready output channel with the normalized value and a
//   saturation flag, held in an output register until the receiver takes it
// cfg_we/cfg_index/cfg_data: register writes; the user must write them only
//   while the block is idle, which the block itself does not enforce
// throughput: one item at a time, one voxel store read-modify-write at a time
//   splat: a split step, then per corner inside the grid two coefficient steps,
//   a product step with the store read and a write step; others are skipped
//   read: a store read, then the voxel clear and the bit-serial divider
// a read index at or beyond GRID_EDGE gives a zero result
// reset: after rst_n rises the store is swept to zero, all GRID_EDGE^3 voxels
//   (32768 at the default), during which items.ready is low
// a stalled receiver holds the finished result; the next item is taken
//   but its result waits until the output register frees up
module trilinear_splat_normalize_unit #(
    parameter int GRID_EDGE = 32,
    parameter int FRAC_BITS = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [tsn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tsn_pkg::CFG_DATA_W-1:0] cfg_data,
    tsn_in_if.sink    items,
    tsn_out_if.source results
);

    import tsn_pkg::*;

    localparam int DEPTH  = GRID_EDGE * GRID_EDGE * GRID_EDGE;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = AW + 1;
    localparam int CW     = SCALED_W - FRAC_BITS;
    localparam int CRD_W  = CW + 1;
    localparam int FW     = FRAC_BITS + 1;
    localparam int PW     = 3 * FW;
    localparam int MUL_W  = POS_W + SCALE_W;
    localparam int SH_R   = (3 * FRAC_BITS >= 16) ? 3 * FRAC_BITS - 16 : 0;
    localparam int SH_L   = (3 * FRAC_BITS >= 16) ? 0 : 16 - 3 * FRAC_BITS;
    localparam int CMP_W  = 18;
    localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SPLIT, S_COEF1, S_COEF2, S_PROD, S_WRITE,
        S_RD_WAIT, S_DIV, S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [GSIZE_W-1:0] gsx_reg, gsy_reg, gsz_reg;
    logic [SCALE_W-1:0] scale_reg;

    // captured item
    logic [POS_W-1:0]           px_reg, py_reg, pz_reg;
    logic signed [WEIGHT_W-1:0] w_reg;
    logic [AW-1:0]              addr_reg;

    // split and corner datapath
    logic [CW-1:0]        cx_reg, cy_reg, cz_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg, fz_reg;
    logic [2:0]           k_reg;
    logic [2*FW-1:0]      wxy_reg;
    logic [FW-1:0]        wz_reg;
    logic [COEF_W-1:0]    c_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [CNT_W-1:0] clr_reg;
    logic             out_valid_reg;
    logic signed [OUT_W-1:0] out_value_reg;
    logic             out_sat_reg;
    logic signed [OUT_W-1:0] res_value_reg;
    logic             res_sat_reg;
    logic             neg_reg;

    // combinational helpers
    logic [SCALED_W-1:0] sx, sy, sz;
    logic [FW-1:0]       wx_sel, wy_sel, wz_sel;
    logic [CRD_W-1:0]    xc, yc, zc;
    logic [CMP_W-1:0]    gx_eff, gy_eff, gz_eff;
    logic                corner_in;
    logic [AW-1:0]       corner_addr, read_addr;
    logic                read_off;
    logic [PW-1:0]       p_full;
    logic [COEF_W-1:0]   c_next;
    logic                accept;
    logic                out_load;

    // store ports
    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [STORE_W-1:0]  rd_data, wr_data;
    logic [VALUE_W-1:0]  old_val;
    logic [WSUM_W-1:0]   old_wt;
    logic signed [VALUE_W-1:0] old_sval;
    logic [VALUE_W-1:0]  mag;

    // divider
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_q;
    logic [WSUM_W-1:0] div_den;
    logic signed [OUT_W-1:0] q_value;
    logic             q_sat;

    assign accept        = items.valid && items.ready;
    assign items.ready   = (state_reg == S_IDLE);
    assign results.valid = out_valid_reg;
    assign results.voxel_value = out_value_reg;
    assign results.saturated   = out_sat_reg;

    // finished result moves into the output register
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || results.ready);

    assign sx = SCALED_W'((MUL_W'(px_reg) * MUL_W'(scale_reg)) >> SCALE_FRAC);
    assign sy = SCALED_W'((MUL_W'(py_reg) * MUL_W'(scale_reg)) >> SCALE_FRAC);
    assign sz = SCALED_W'((MUL_W'(pz_reg) * MUL_W'(scale_reg)) >> SCALE_FRAC);

    // corner k: bit 0 selects upper x, bit 1 upper y, bit 2 upper z
    assign wx_sel = k_reg[0] ? FW'(fx_reg) : ONE - FW'(fx_reg);
    assign wy_sel = k_reg[1] ? FW'(fy_reg) : ONE - FW'(fy_reg);
    assign wz_sel = k_reg[2] ? FW'(fz_reg) : ONE - FW'(fz_reg);
    assign xc = CRD_W'(cx_reg) + CRD_W'(k_reg[0]);
    assign yc = CRD_W'(cy_reg) + CRD_W'(k_reg[1]);
    assign zc = CRD_W'(cz_reg) + CRD_W'(k_reg[2]);

    // grid size in effect is the register clipped to the grid edge
    assign gx_eff = (CMP_W'(gsx_reg) < CMP_W'(GRID_EDGE)) ? CMP_W'(gsx_reg) : CMP_W'(GRID_EDGE);
    assign gy_eff = (CMP_W'(gsy_reg) < CMP_W'(GRID_EDGE)) ? CMP_W'(gsy_reg) : CMP_W'(GRID_EDGE);
    assign gz_eff = (CMP_W'(gsz_reg) < CMP_W'(GRID_EDGE)) ? CMP_W'(gsz_reg) : CMP_W'(GRID_EDGE);
    assign corner_in = (CMP_W'(xc) < gx_eff) && (CMP_W'(yc) < gy_eff)
                    && (CMP_W'(zc) < gz_eff);
    assign corner_addr = AW'((zc * GRID_EDGE + yc) * GRID_EDGE + xc);

    assign read_off = (CMP_W'(items.read_x) >= CMP_W'(GRID_EDGE))
                   || (CMP_W'(items.read_y) >= CMP_W'(GRID_EDGE))
                   || (CMP_W'(items.read_z) >= CMP_W'(GRID_EDGE));
    assign read_addr = AW'((items.read_z * GRID_EDGE + items.read_y) * GRID_EDGE
                           + items.read_x);

    // coefficient rescaled to 16 fraction bits
    assign p_full = PW'(wxy_reg) * PW'(wz_reg);
    assign c_next = COEF_W'((p_full >> SH_R) << SH_L);

    // store access
    assign old_val  = rd_data[STORE_W-1:WSUM_W];
    assign old_wt   = rd_data[WSUM_W-1:0];
    assign old_sval = old_val;
    assign rd_en    = (state_reg == S_PROD) || accept;
    assign rd_addr  = (state_reg == S_PROD) ? addr_reg : read_addr;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg[AW-1:0];
            end
            S_WRITE:
            begin
                wr_en   = 1'b1;
                wr_data = {old_val + VALUE_W'(prod_reg >>> 16),
                           old_wt + WSUM_W'(c_reg)};
            end
            S_RD_WAIT:
            begin
                wr_en = 1'b1; // read clears the voxel
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // divide magnitude of value * 2^16 by max(weight, 1)
    assign mag       = old_sval[VALUE_W-1] ? VALUE_W'(-old_sval) : old_val;
    assign div_start = (state_reg == S_RD_WAIT);
    assign div_num   = {mag, 16'd0};
    assign div_den   = (old_wt == '0) ? WSUM_W'(1) : old_wt;

    always_comb
    begin
        q_sat   = 1'b0;
        q_value = OUT_W'(div_q);
        if (neg_reg)
        begin
            if (div_q > NUM_W'(64'd8388608))
            begin
                q_sat   = 1'b1;
                q_value = OUT_W'(24'h800000);
            end
            else
            begin
                q_value = OUT_W'(-div_q);
            end
        end
        else if (div_q > NUM_W'(64'd8388607))
        begin
            q_sat   = 1'b1;
            q_value = OUT_W'(24'h7fffff);
        end
    end

    tsn_store #(.AW(AW), .DW(STORE_W), .DEPTH(DEPTH)) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    tsn_div #(.NW(NUM_W), .DW(WSUM_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            gsx_reg       <= GSIZE_W'(32);
            gsy_reg       <= GSIZE_W'(32);
            gsz_reg       <= GSIZE_W'(32);
            scale_reg     <= SCALE_W'(256);
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_GRID_X: gsx_reg   <= cfg_data[GSIZE_W-1:0];
                    CFG_GRID_Y: gsy_reg   <= cfg_data[GSIZE_W-1:0];
                    CFG_GRID_Z: gsz_reg   <= cfg_data[GSIZE_W-1:0];
                    CFG_SCALE:  scale_reg <= cfg_data[SCALE_W-1:0];
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.valid && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CNT_W'(1);
                    if (clr_reg == CNT_W'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (items.kind == KIND_SPLAT)
                        begin
                            state_reg <= S_SPLIT;
                        end
                        else if (read_off)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_RD_WAIT;
                        end
                    end
                end
                S_SPLIT:
                begin
                    k_reg     <= '0;
                    state_reg <= S_COEF1;
                end
                S_COEF1:
                begin
                    if (corner_in)
                    begin
                        state_reg <= S_COEF2;
                    end
                    else if (k_reg == 3'd7)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg <= k_reg + 3'd1;
                    end
                end
                S_COEF2: state_reg <= S_PROD;
                S_PROD:  state_reg <= S_WRITE;
                S_WRITE:
                begin
                    if (k_reg == 3'd7)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= S_COEF1;
                    end
                end
                S_RD_WAIT: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg        <= items.pos_x;
            py_reg        <= items.pos_y;
            pz_reg        <= items.pos_z;
            w_reg         <= items.atom_weight;
            addr_reg      <= read_addr;
            res_value_reg <= '0;
            res_sat_reg   <= 1'b0;
        end
        if (state_reg == S_SPLIT)
        begin
            cx_reg <= sx[SCALED_W-1:FRAC_BITS];
            cy_reg <= sy[SCALED_W-1:FRAC_BITS];
            cz_reg <= sz[SCALED_W-1:FRAC_BITS];
            fx_reg <= sx[FRAC_BITS-1:0];
            fy_reg <= sy[FRAC_BITS-1:0];
            fz_reg <= sz[FRAC_BITS-1:0];
        end
        if (state_reg == S_COEF1)
        begin
            wxy_reg  <= (2*FW)'(wx_sel) * (2*FW)'(wy_sel);
            wz_reg   <= wz_sel;
            addr_reg <= corner_addr;
        end
        if (state_reg == S_COEF2)
        begin
            c_reg <= c_next;
        end
        if (state_reg == S_PROD)
        begin
            prod_reg <= PROD_W'(w_reg) * $signed({1'b0, c_reg});
        end
        if (state_reg == S_RD_WAIT)
        begin
            neg_reg <= old_val[VALUE_W-1];
        end
        if (state_reg == S_DIV && div_done)
        begin
            res_value_reg <= q_value;
            res_sat_reg   <= q_sat;
        end
        if (out_load)
        begin
            out_value_reg <= res_value_reg;
            out_sat_reg   <= res_sat_reg;
        end
    end

    `TSN_ASSERT_NOW(a_no_item_in_clear, state_reg == S_CLEAR, !items.ready)
    `TSN_ASSERT_NEXT(a_item_starts_work, accept, state_reg != S_IDLE)
    `TSN_ASSERT_NOW(a_div_only_for_read, div_done, state_reg == S_DIV)
    `TSN_ASSERT_NEXT(a_result_waits, results.valid && !results.ready, results.valid)

endmodule

`default_nettype wire
